// ===== design/lav_pkg.sv =====
// shared widths, types, rounding and clamping helpers of the look-at view matrix block
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int AXIS_W    = FRAC_BITS + 2;
  localparam int THR_W     = 16;
  localparam int WIDE_W    = 64;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int NRM_W     = 32;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = NRM_W + FRAC_BITS + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam axis_t AXIS_ONE = axis_t'(1) <<< FRAC_BITS;
  localparam wide_t WIDE_ONE = wide_t'(1) <<< FRAC_BITS;

  // shift right by the fraction width, rounding half away from zero
  function automatic wide_t shr_round(input wide_t v);
    logic [WIDE_W-1:0] m;
    m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    m = (m + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[WIDE_W-1] ? -wide_t'(m) : wide_t'(m);
  endfunction

  // clamp to plus or minus one
  function automatic axis_t clamp_one(input wide_t v);
    axis_t r;
    if (v > WIDE_ONE) begin
      r = AXIS_ONE;
    end else if (v < -WIDE_ONE) begin
      r = -AXIS_ONE;
    end else begin
      r = axis_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/lav_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module lav_isqrt #(
  parameter int SBW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [lav_pkg::SQ_W-1:0]   x_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       vld_o,
  output logic [lav_pkg::ROOT_W-1:0] root_o,
  output logic [SBW-1:0]             sb_o
);
  import lav_pkg::*;

  localparam int STEPS = SQ_W / 2;

  logic [SQ_W-1:0] x_q  [STEPS];
  logic [SQ_W-1:0] r_q  [STEPS];
  logic [SBW-1:0]  sb_q [STEPS];
  logic            vld_q [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
    logic [SQ_W-1:0] x_prev, r_prev, trial, x_d, r_d;
    logic            v_prev;
    logic [SBW-1:0]  sb_prev;

    if (j == 0) begin : g_first
      assign x_prev  = x_i;
      assign r_prev  = '0;
      assign v_prev  = vld_i;
      assign sb_prev = sb_i;
    end else begin : g_next
      assign x_prev  = x_q[j-1];
      assign r_prev  = r_q[j-1];
      assign v_prev  = vld_q[j-1];
      assign sb_prev = sb_q[j-1];
    end

    always_comb begin
      trial = r_prev + BIT;
      if (x_prev >= trial) begin
        x_d = x_prev - trial;
        r_d = (r_prev >> 1) + BIT;
      end else begin
        x_d = x_prev;
        r_d = r_prev >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j]  <= x_d;
        r_q[j]  <= r_d;
        sb_q[j] <= sb_prev;
      end
    end
  end

  assign vld_o  = vld_q[STEPS-1];
  assign root_o = r_q[STEPS-1][ROOT_W-1:0];
  assign sb_o   = sb_q[STEPS-1];

endmodule

// ===== design/lav_div.sv =====
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module lav_div #(
  parameter int SBW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [lav_pkg::NUM_W-1:0]  num_i [3],
  input  logic [lav_pkg::ROOT_W-1:0] den_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       vld_o,
  output logic [lav_pkg::QUO_W-1:0]  quo_o [3],
  output logic [SBW-1:0]             sb_o
);
  import lav_pkg::*;

  logic [NUM_W-1:0]  rem_q [QUO_W][3];
  logic [QUO_W-1:0]  quo_q [QUO_W][3];
  logic [ROOT_W-1:0] den_q [QUO_W];
  logic [SBW-1:0]    sb_q  [QUO_W];
  logic              vld_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int B = QUO_W - 1 - s;
    logic [NUM_W-1:0]  rem_prev [3];
    logic [QUO_W-1:0]  quo_prev [3];
    logic [NUM_W-1:0]  rem_d [3];
    logic [QUO_W-1:0]  quo_d [3];
    logic [ROOT_W-1:0] den_prev;
    logic [NUM_W-1:0]  dsh;
    logic              v_prev;
    logic [SBW-1:0]    sb_prev;

    if (s == 0) begin : g_first
      assign rem_prev = num_i;
      assign quo_prev = '{default: '0};
      assign den_prev = den_i;
      assign v_prev   = vld_i;
      assign sb_prev  = sb_i;
    end else begin : g_next
      assign rem_prev = rem_q[s-1];
      assign quo_prev = quo_q[s-1];
      assign den_prev = den_q[s-1];
      assign v_prev   = vld_q[s-1];
      assign sb_prev  = sb_q[s-1];
    end

    always_comb begin
      dsh = NUM_W'(den_prev) << B;
      for (int l = 0; l < 3; l++) begin
        if (rem_prev[l] >= dsh) begin
          rem_d[l] = rem_prev[l] - dsh;
          quo_d[l] = quo_prev[l] | (QUO_W'(1) << B);
        end else begin
          rem_d[l] = rem_prev[l];
          quo_d[l] = quo_prev[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_prev;
        sb_q[s]  <= sb_prev;
      end
    end
  end

  assign vld_o = vld_q[QUO_W-1];
  assign quo_o = quo_q[QUO_W-1];
  assign sb_o  = sb_q[QUO_W-1];

endmodule

// ===== design/lav_norm.sv =====
// pipelined vector normaliser: scale, sum of squares, square root, divide, sign and clamp
module lav_norm #(
  parameter int IW  = 33,
  parameter int SBW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [IW-1:0] v_i [3],
  input  logic [SBW-1:0]       sb_i,
  output logic                 vld_o,
  output lav_pkg::axis_t       vec_o [3],
  output logic                 zero_o,
  output logic [SBW-1:0]       sb_o
);
  import lav_pkg::*;

  localparam int PW  = $clog2(IW);
  localparam int ISB = SBW + 4 + 3 * NRM_W;
  localparam int DSB = SBW + 4;

  // stage a: magnitudes and leading one of the largest
  logic [IW-1:0]    mag [3];
  logic [IW-1:0]    mmax;
  logic [PW-1:0]    pos;
  logic [IW-1:0]    a_mag_q [3];
  logic             a_neg_q [3];
  logic [PW-1:0]    a_pos_q;
  logic             a_zero_q, a_vld_q;
  logic [SBW-1:0]   a_sb_q;

  always_comb begin
    mmax = '0;
    pos  = '0;
    for (int l = 0; l < 3; l++) begin
      mag[l] = v_i[l][IW-1] ? IW'(-v_i[l]) : IW'(v_i[l]);
      if (mag[l] > mmax) mmax = mag[l];
    end
    for (int b = 0; b < IW; b++) begin
      if (mmax[b]) pos = PW'(b);
    end
  end

  // stage b: scale so the largest magnitude sits in [2^30, 2^31]
  logic [PW-1:0]    k;
  logic [IW:0]      rnd;
  logic [WIDE_W-1:0] upsh;
  logic [NRM_W-1:0] w [3];
  logic [NRM_W-1:0] b_w_q [3];
  logic             b_neg_q [3];
  logic             b_zero_q, b_vld_q;
  logic [SBW-1:0]   b_sb_q;

  always_comb begin
    rnd  = '0;
    upsh = '0;
    if (a_pos_q >= PW'(NRM_W - 1)) begin
      k = a_pos_q - PW'(NRM_W - 2);
      for (int l = 0; l < 3; l++) begin
        rnd  = ({1'b0, a_mag_q[l]} + (((IW+1)'(1) << k) >> 1)) >> k;
        w[l] = NRM_W'(rnd);
      end
    end else begin
      k = PW'(NRM_W - 2) - a_pos_q;
      for (int l = 0; l < 3; l++) begin
        upsh = WIDE_W'(a_mag_q[l]) << k;
        w[l] = NRM_W'(upsh);
      end
    end
  end

  // stage c: squares
  logic [SQ_W-1:0]  c_sq_q [3];
  logic [NRM_W-1:0] c_w_q [3];
  logic             c_neg_q [3];
  logic             c_zero_q, c_vld_q;
  logic [SBW-1:0]   c_sb_q;

  // stage d: sum of squares
  logic [SQ_W-1:0]  d_sum_q;
  logic [NRM_W-1:0] d_w_q [3];
  logic             d_neg_q [3];
  logic             d_zero_q, d_vld_q;
  logic [SBW-1:0]   d_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        a_mag_q[l] <= mag[l];
        a_neg_q[l] <= v_i[l][IW-1];
        b_w_q[l]   <= w[l];
        b_neg_q[l] <= a_neg_q[l];
        c_sq_q[l]  <= b_w_q[l] * b_w_q[l];
        c_w_q[l]   <= b_w_q[l];
        c_neg_q[l] <= b_neg_q[l];
        d_w_q[l]   <= c_w_q[l];
        d_neg_q[l] <= c_neg_q[l];
      end
      a_pos_q  <= pos;
      a_zero_q <= (mmax == '0);
      a_sb_q   <= sb_i;
      b_zero_q <= a_zero_q;
      b_sb_q   <= a_sb_q;
      c_zero_q <= b_zero_q;
      c_sb_q   <= b_sb_q;
      d_sum_q  <= c_sq_q[0] + c_sq_q[1] + c_sq_q[2];
      d_zero_q <= c_zero_q;
      d_sb_q   <= c_sb_q;
    end
  end

  // square root
  logic              s_vld;
  logic [ROOT_W-1:0] s_len;
  logic [ISB-1:0]    s_sb;
  logic [SBW-1:0]    s_sbx;
  logic              s_zero;
  logic              s_neg [3];
  logic [NRM_W-1:0]  s_w [3];

  lav_isqrt #(.SBW(ISB)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (d_vld_q),
    .x_i    (d_sum_q),
    .sb_i   ({d_sb_q, d_zero_q, d_neg_q[0], d_neg_q[1], d_neg_q[2],
              d_w_q[0], d_w_q[1], d_w_q[2]}),
    .vld_o  (s_vld),
    .root_o (s_len),
    .sb_o   (s_sb)
  );

  assign {s_sbx, s_zero, s_neg[0], s_neg[1], s_neg[2], s_w[0], s_w[1], s_w[2]} = s_sb;

  // stage e: rounded numerators
  logic [NUM_W-1:0]  e_num_q [3];
  logic [ROOT_W-1:0] e_den_q;
  logic              e_neg_q [3];
  logic              e_zero_q, e_vld_q;
  logic [SBW-1:0]    e_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        e_num_q[l] <= (NUM_W'(s_w[l]) << FRAC_BITS) + NUM_W'(s_len >> 1);
        e_neg_q[l] <= s_neg[l];
      end
      e_den_q  <= s_len;
      e_zero_q <= s_zero;
      e_sb_q   <= s_sbx;
    end
  end

  // division
  logic             q_vld;
  logic [QUO_W-1:0] q_quo [3];
  logic [DSB-1:0]   q_sb;
  logic [SBW-1:0]   q_sbx;
  logic             q_zero;
  logic             q_neg [3];

  lav_div #(.SBW(DSB)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (e_vld_q),
    .num_i  (e_num_q),
    .den_i  (e_den_q),
    .sb_i   ({e_sb_q, e_zero_q, e_neg_q[0], e_neg_q[1], e_neg_q[2]}),
    .vld_o  (q_vld),
    .quo_o  (q_quo),
    .sb_o   (q_sb)
  );

  assign {q_sbx, q_zero, q_neg[0], q_neg[1], q_neg[2]} = q_sb;

  // stage f: sign and clamp
  logic [QUO_W-1:0] qm [3];
  axis_t            f_vec_q [3];
  logic             f_zero_q, f_vld_q;
  logic [SBW-1:0]   f_sb_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qm[l] = (q_quo[l] > QUO_W'(AXIS_ONE)) ? QUO_W'(AXIS_ONE) : q_quo[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en_i) begin
      f_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        f_vec_q[l] <= q_neg[l] ? -axis_t'(qm[l]) : axis_t'(qm[l]);
      end
      f_zero_q <= q_zero;
      f_sb_q   <= q_sbx;
    end
  end

  assign vld_o  = f_vld_q;
  assign vec_o  = f_vec_q;
  assign zero_o = f_zero_q;
  assign sb_o   = f_sb_q;

endmodule

// ===== design/look_at_view_matrix.sv =====
// top level of the look-at view matrix pipeline
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+----------------
//  input   | eye_*_i, target_*_i, up_*_i               | in  | in_valid_i / in_ready_o
//  output  | side_*_o, upaxis_*_o, back_*_o, shift_*_o | out | out_valid_o / out_ready_i
//  config  | cfg_data_i (near threshold)               | in  | cfg_valid_i / cfg_ready_o
//
// one request enters per cycle unless the output stalls; the pipe runs through the two
// normalisers (32-stage square root and 17-stage divider each) plus the projection, cross and
// translation stages
// reset clears the valid bits and loads the near threshold with one
// a stalled output freezes every stage at once, so nothing is lost or repeated
module look_at_view_matrix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lav_pkg::THR_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lav_pkg::coord_t            eye_x_i,
  input  lav_pkg::coord_t            eye_y_i,
  input  lav_pkg::coord_t            eye_z_i,
  input  lav_pkg::coord_t            target_x_i,
  input  lav_pkg::coord_t            target_y_i,
  input  lav_pkg::coord_t            target_z_i,
  input  lav_pkg::coord_t            up_x_i,
  input  lav_pkg::coord_t            up_y_i,
  input  lav_pkg::coord_t            up_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lav_pkg::axis_t             side_x_o,
  output lav_pkg::axis_t             side_y_o,
  output lav_pkg::axis_t             side_z_o,
  output lav_pkg::axis_t             upaxis_x_o,
  output lav_pkg::axis_t             upaxis_y_o,
  output lav_pkg::axis_t             upaxis_z_o,
  output lav_pkg::axis_t             back_x_o,
  output lav_pkg::axis_t             back_y_o,
  output lav_pkg::axis_t             back_z_o,
  output lav_pkg::coord_t            shift_0_o,
  output lav_pkg::coord_t            shift_1_o,
  output lav_pkg::coord_t            shift_2_o
);
  import lav_pkg::*;

  localparam int DW      = COORD_W + 1;        // target minus eye
  localparam int HALF_W  = COORD_W / 2;        // magnitude range of the short test
  localparam int SSQ_W   = 2 * HALF_W + 2;     // sum of three small squares
  localparam int PROD_W  = AXIS_W + COORD_W;   // axis times coordinate
  localparam int ALPHA_W = COORD_W + 2;        // projection length
  localparam int PA_W    = ALPHA_W + AXIS_W;
  localparam int V0_W    = COORD_W + 3;        // projected up vector
  localparam int CP_W    = 2 * AXIS_W;
  localparam int SB1_W   = 6 * COORD_W + 1;
  localparam int SB2_W   = 3 * COORD_W + 3 * AXIS_W;
  localparam wide_t SAT_HI = wide_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

  typedef logic signed [DW-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // global advance: the whole pipe moves unless a finished result is held
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // near threshold register, always writable
  logic [THR_W-1:0] thr_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  coord_t eye_in [3];
  coord_t tgt_in [3];
  coord_t up_in  [3];

  assign eye_in = '{eye_x_i, eye_y_i, eye_z_i};
  assign tgt_in = '{target_x_i, target_y_i, target_z_i};
  assign up_in  = '{up_x_i, up_y_i, up_z_i};

  // ---------------------------------------------------------------------------
  // front: view direction and the short-length test
  // ---------------------------------------------------------------------------
  diff_t          f1_d_q [3];
  coord_t         f1_eye_q [3], f1_up_q [3];
  diff_t          f2_d_q [3];
  coord_t         f2_eye_q [3], f2_up_q [3];
  logic [2*HALF_W-1:0] f2_sq_q [3];
  logic [2*THR_W-1:0]  f2_thr2_q;
  logic           f2_small_q;
  diff_t          f3_d_q [3];
  coord_t         f3_eye_q [3], f3_up_q [3];
  logic           f3_near_q;
  logic           f1_vld_q, f2_vld_q, f3_vld_q;

  logic [DW-1:0]  dmag [3];
  logic           low_mag;
  logic [SSQ_W-1:0] ssq;

  always_comb begin
    low_mag = 1'b1;
    for (int l = 0; l < 3; l++) begin
      dmag[l] = f1_d_q[l][DW-1] ? DW'(-f1_d_q[l]) : DW'(f1_d_q[l]);
      if (dmag[l][DW-1:HALF_W] != '0) low_mag = 1'b0;
    end
    ssq = SSQ_W'(f2_sq_q[0]) + SSQ_W'(f2_sq_q[1]) + SSQ_W'(f2_sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        f1_d_q[l]   <= diff_t'(tgt_in[l]) - diff_t'(eye_in[l]);
        f1_eye_q[l] <= eye_in[l];
        f1_up_q[l]  <= up_in[l];
        f2_d_q[l]   <= f1_d_q[l];
        f2_eye_q[l] <= f1_eye_q[l];
        f2_up_q[l]  <= f1_up_q[l];
        f2_sq_q[l]  <= dmag[l][HALF_W-1:0] * dmag[l][HALF_W-1:0];
        f3_d_q[l]   <= f2_d_q[l];
        f3_eye_q[l] <= f2_eye_q[l];
        f3_up_q[l]  <= f2_up_q[l];
      end
      f2_thr2_q  <= thr_q * thr_q;
      f2_small_q <= low_mag;
      f3_near_q  <= f2_small_q && (ssq <= SSQ_W'(f2_thr2_q));
    end
  end

  // ---------------------------------------------------------------------------
  // first normaliser: view direction n
  // ---------------------------------------------------------------------------
  logic             n1_vld, n1_zero;
  axis_t            n1_vec [3];
  logic [SB1_W-1:0] n1_sb;
  coord_t           n1_eye [3], n1_up [3];
  logic             n1_near;
  axis_t            n_sel [3];

  lav_norm #(.IW(DW), .SBW(SB1_W)) u_norm_view (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (f3_vld_q),
    .v_i    (f3_d_q),
    .sb_i   ({f3_eye_q[0], f3_eye_q[1], f3_eye_q[2],
              f3_up_q[0], f3_up_q[1], f3_up_q[2], f3_near_q}),
    .vld_o  (n1_vld),
    .vec_o  (n1_vec),
    .zero_o (n1_zero),
    .sb_o   (n1_sb)
  );

  assign {n1_eye[0], n1_eye[1], n1_eye[2], n1_up[0], n1_up[1], n1_up[2], n1_near} = n1_sb;

  // short or zero view direction falls back to +z
  always_comb begin
    if (n1_near || n1_zero) begin
      n_sel = '{axis_t'(0), axis_t'(0), AXIS_ONE};
    end else begin
      n_sel = n1_vec;
    end
  end

  // ---------------------------------------------------------------------------
  // projection of up onto the plane normal to n
  // ---------------------------------------------------------------------------
  axis_t                   p1_n_q [3], p2_n_q [3], p3_n_q [3], p4_n_q [3];
  coord_t                  p1_eye_q [3], p2_eye_q [3], p3_eye_q [3], p4_eye_q [3];
  coord_t                  p1_up_q [3], p2_up_q [3], p3_up_q [3];
  prod_t                   p1_prod_q [3];
  logic signed [ALPHA_W-1:0] p2_alpha_q;
  logic signed [PA_W-1:0]  p3_pa_q [3];
  logic signed [V0_W-1:0]  p4_v0_q [3];
  logic                    p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  wide_t                   alpha_full;

  assign alpha_full = shr_round(wide_t'(p1_prod_q[0]) + wide_t'(p1_prod_q[1])
                                + wide_t'(p1_prod_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= n1_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        p1_n_q[l]    <= n_sel[l];
        p1_eye_q[l]  <= n1_eye[l];
        p1_up_q[l]   <= n1_up[l];
        p1_prod_q[l] <= n_sel[l] * n1_up[l];
        p2_n_q[l]    <= p1_n_q[l];
        p2_eye_q[l]  <= p1_eye_q[l];
        p2_up_q[l]   <= p1_up_q[l];
        p3_n_q[l]    <= p2_n_q[l];
        p3_eye_q[l]  <= p2_eye_q[l];
        p3_up_q[l]   <= p2_up_q[l];
        p3_pa_q[l]   <= p2_alpha_q * p2_n_q[l];
        p4_n_q[l]    <= p3_n_q[l];
        p4_eye_q[l]  <= p3_eye_q[l];
        p4_v0_q[l]   <= V0_W'(p3_up_q[l]) - V0_W'(shr_round(wide_t'(p3_pa_q[l])));
      end
      p2_alpha_q <= ALPHA_W'(alpha_full);
    end
  end

  // ---------------------------------------------------------------------------
  // second normaliser: up axis
  // ---------------------------------------------------------------------------
  logic             n2_vld, n2_zero;
  axis_t            n2_vec [3];
  logic [SB2_W-1:0] n2_sb;
  coord_t           n2_eye [3];
  axis_t            n2_n [3];
  axis_t            cy_sel [3], cz_sel [3];

  lav_norm #(.IW(V0_W), .SBW(SB2_W)) u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (p4_vld_q),
    .v_i    (p4_v0_q),
    .sb_i   ({p4_eye_q[0], p4_eye_q[1], p4_eye_q[2],
              p4_n_q[0], p4_n_q[1], p4_n_q[2]}),
    .vld_o  (n2_vld),
    .vec_o  (n2_vec),
    .zero_o (n2_zero),
    .sb_o   (n2_sb)
  );

  assign {n2_eye[0], n2_eye[1], n2_eye[2], n2_n[0], n2_n[1], n2_n[2]} = n2_sb;

  // up parallel to the view direction falls back to +y; back axis is -n
  always_comb begin
    if (n2_zero) begin
      cy_sel = '{axis_t'(0), AXIS_ONE, axis_t'(0)};
    end else begin
      cy_sel = n2_vec;
    end
    for (int l = 0; l < 3; l++) begin
      cz_sel[l] = -n2_n[l];
    end
  end

  // ---------------------------------------------------------------------------
  // side axis = up axis cross back
  // ---------------------------------------------------------------------------
  logic signed [CP_W-1:0] x1_pa_q [3], x1_pb_q [3];
  axis_t                  x1_cy_q [3], x1_cz_q [3], x2_cy_q [3], x2_cz_q [3], x2_cx_q [3];
  coord_t                 x1_eye_q [3], x2_eye_q [3];
  logic                   x1_vld_q, x2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
    end else if (adv) begin
      x1_vld_q <= n2_vld;
      x2_vld_q <= x1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_pa_q[0] <= cy_sel[1] * cz_sel[2];
      x1_pb_q[0] <= cy_sel[2] * cz_sel[1];
      x1_pa_q[1] <= cy_sel[2] * cz_sel[0];
      x1_pb_q[1] <= cy_sel[0] * cz_sel[2];
      x1_pa_q[2] <= cy_sel[0] * cz_sel[1];
      x1_pb_q[2] <= cy_sel[1] * cz_sel[0];
      for (int l = 0; l < 3; l++) begin
        x1_cy_q[l]  <= cy_sel[l];
        x1_cz_q[l]  <= cz_sel[l];
        x1_eye_q[l] <= n2_eye[l];
        x2_cx_q[l]  <= clamp_one(shr_round(wide_t'(x1_pa_q[l]) - wide_t'(x1_pb_q[l])));
        x2_cy_q[l]  <= x1_cy_q[l];
        x2_cz_q[l]  <= x1_cz_q[l];
        x2_eye_q[l] <= x1_eye_q[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // translation column: minus each axis dotted with the eye, saturated
  // ---------------------------------------------------------------------------
  axis_t  x2_ax [3][3];
  prod_t  t1_p_q [3][3];
  axis_t  t1_ax_q [3][3];
  axis_t  t2_ax_q [3][3];
  coord_t t2_sh_q [3];
  logic   t1_vld_q, t2_vld_q;
  wide_t  tsum [3];

  assign x2_ax[0] = x2_cx_q;
  assign x2_ax[1] = x2_cy_q;
  assign x2_ax[2] = x2_cz_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tsum[r] = -shr_round(wide_t'(t1_p_q[r][0]) + wide_t'(t1_p_q[r][1])
                           + wide_t'(t1_p_q[r][2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
    end else if (adv) begin
      t1_vld_q <= x2_vld_q;
      t2_vld_q <= t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int l = 0; l < 3; l++) begin
          t1_p_q[r][l]  <= x2_ax[r][l] * x2_eye_q[l];
          t1_ax_q[r][l] <= x2_ax[r][l];
          t2_ax_q[r][l] <= t1_ax_q[r][l];
        end
        if (tsum[r] > SAT_HI) begin
          t2_sh_q[r] <= coord_t'(SAT_HI);
        end else if (tsum[r] < SAT_LO) begin
          t2_sh_q[r] <= coord_t'(SAT_LO);
        end else begin
          t2_sh_q[r] <= coord_t'(tsum[r]);
        end
      end
    end
  end

  assign out_valid_o = t2_vld_q;
  assign side_x_o    = t2_ax_q[0][0];
  assign side_y_o    = t2_ax_q[0][1];
  assign side_z_o    = t2_ax_q[0][2];
  assign upaxis_x_o  = t2_ax_q[1][0];
  assign upaxis_y_o  = t2_ax_q[1][1];
  assign upaxis_z_o  = t2_ax_q[1][2];
  assign back_x_o    = t2_ax_q[2][0];
  assign back_y_o    = t2_ax_q[2][1];
  assign back_z_o    = t2_ax_q[2][2];
  assign shift_0_o   = t2_sh_q[0];
  assign shift_1_o   = t2_sh_q[1];
  assign shift_2_o   = t2_sh_q[2];

endmodule

// ===== design/lav_checker.sv =====
// port-level checks of the look-at view matrix block, bound to the top level
module lav_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input lav_pkg::axis_t side_x_o,
  input lav_pkg::axis_t upaxis_y_o,
  input lav_pkg::axis_t back_z_o,
  input lav_pkg::coord_t shift_0_o
);
  import lav_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // an empty output never blocks new requests
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with free output");

  // one component of each axis stays within plus or minus one
  a_axis_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> side_x_o <= AXIS_ONE && side_x_o >= -AXIS_ONE
                 && upaxis_y_o <= AXIS_ONE && upaxis_y_o >= -AXIS_ONE
                 && back_z_o <= AXIS_ONE && back_z_o >= -AXIS_ONE)
    else $error("axis component out of range");

  // stalled result keeps its translation
  a_shift_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(shift_0_o))
    else $error("translation changed while stalled");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
